[rtl/srie_pkg.sv]
// shared types, constants and helpers of the instruction executor
`timescale 1ns / 1ps
`default_nettype none

package srie_pkg;

  localparam int unsigned XLEN           = 32;
  localparam int unsigned NREGS          = 32;
  localparam int unsigned RIDX_W         = 5;
  localparam int unsigned SHAMT_W        = 13;
  localparam int unsigned JADDR_W        = 28;
  localparam int unsigned IMM_W          = 18;
  localparam int unsigned MADDR_W        = 10;
  localparam int unsigned QDEPTH         = 2;
  localparam int unsigned DATA_WORDS_DEF = 1024;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MULI = 4'd2,
    OP_ADDI = 4'd3,
    OP_BNE  = 4'd4,
    OP_ANDI = 4'd5,
    OP_ORI  = 4'd6,
    OP_J    = 4'd7,
    OP_SLL  = 4'd8,
    OP_SRL  = 4'd9,
    OP_LW   = 4'd10,
    OP_SW   = 4'd11
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               bad;
    logic               wr;
    logic               is_ld;
    logic               is_st;
    logic               use_ra;
    logic               use_rb;
    logic [RIDX_W-1:0]  rd;
    logic [RIDX_W-1:0]  ra;
    logic [RIDX_W-1:0]  rb;
    logic [XLEN-1:0]    imm;
    logic [SHAMT_W-1:0] shamt;
    logic [JADDR_W-1:0] jaddr;
  } dec_t;

  typedef struct packed {
    logic [XLEN-1:0]    next_pc;
    logic               reg_write;
    logic [RIDX_W-1:0]  dest_reg;
    logic [XLEN-1:0]    write_value;
    logic               mem_write;
    logic [MADDR_W-1:0] mem_address;
    logic [XLEN-1:0]    mem_data;
    logic               branch_taken;
    logic               bad_opcode;
  } res_t;

  // stages of the data address reduction
  function automatic int unsigned dmod_lat(input int unsigned words);
    return ((words & (words - 1)) == 0) ? 1 : 4;
  endfunction

endpackage

`default_nettype wire

[rtl/srie_fifo.sv]
// two-entry transaction queue
`timescale 1ns / 1ps
`default_nettype none

module srie_fifo import srie_pkg::*; #(
  parameter type T = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          data_o,
  output logic      empty_o
);

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  T              buf_q [QDEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = buf_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wp_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/srie_front.sv]
// front end: instruction decode and decoupling queue
`timescale 1ns / 1ps
`default_nettype none

module srie_front import srie_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire logic [XLEN-1:0] instr_i,
  input  wire logic            hold_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output dec_t                 head_o,
  output logic                 empty_o
);

  logic [3:0] opc;
  logic       writes;
  logic       q_full;
  dec_t       dec;

  assign opc = instr_i[31:28];

  always_comb begin
    writes     = 1'b0;
    dec        = '0;
    dec.op     = op_e'(opc);
    dec.rd     = instr_i[27:23];
    dec.ra     = instr_i[22:18];
    dec.rb     = instr_i[27:23];
    dec.imm    = {{(XLEN - IMM_W){instr_i[IMM_W-1]}}, instr_i[IMM_W-1:0]};
    dec.shamt  = instr_i[SHAMT_W-1:0];
    dec.jaddr  = instr_i[JADDR_W-1:0];
    case (opc)
      OP_ADD, OP_SUB: begin
        writes     = 1'b1;
        dec.use_ra = 1'b1;
        dec.use_rb = 1'b1;
        dec.rb     = instr_i[17:13];
      end
      OP_MULI, OP_ADDI, OP_ANDI, OP_ORI, OP_SLL, OP_SRL: begin
        writes     = 1'b1;
        dec.use_ra = 1'b1;
      end
      OP_LW: begin
        writes     = 1'b1;
        dec.is_ld  = 1'b1;
        dec.use_ra = 1'b1;
      end
      OP_BNE: begin
        dec.use_ra = 1'b1;
        dec.use_rb = 1'b1;
      end
      OP_SW: begin
        dec.is_st  = 1'b1;
        dec.use_ra = 1'b1;
        dec.use_rb = 1'b1;
      end
      OP_J: begin
        writes = 1'b0;
      end
      default: begin
        dec.op  = OP_ADD;
        dec.bad = 1'b1;
      end
    endcase
    // r0 is never written
    dec.wr = writes && (dec.rd != '0);
  end

  assign full_o = q_full || hold_i;

  srie_fifo #(.T(dec_t)) u_dq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && !full_o),
    .data_i  (dec),
    .full_o  (q_full),
    .pop_i   (pop_i),
    .data_o  (head_o),
    .empty_o (empty_o)
  );

endmodule

`default_nettype wire

[rtl/srie_dmod.sv]
// pipelined reduction of a data address modulo the store depth
`timescale 1ns / 1ps
`default_nettype none

module srie_dmod import srie_pkg::*; #(
  parameter int unsigned DATA_WORDS = DATA_WORDS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          adv_i,
  input  wire logic [XLEN-1:0]               x_i,
  output logic      [$clog2(DATA_WORDS)-1:0] idx_o
);

  localparam int unsigned AW = $clog2(DATA_WORDS);

  if (dmod_lat(DATA_WORDS) == 1) begin : g_pow2
    logic [AW-1:0] idx_q;

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        idx_q <= x_i[AW-1:0];
      end
    end

    assign idx_o = idx_q;
  end else begin : g_recip
    // x * floor(2^SH / K) >> SH underestimates x / K by at most one
    localparam int unsigned SH    = XLEN + AW;
    localparam logic [63:0] RECIP = (64'd1 << SH) / 64'(DATA_WORDS);
    localparam logic [31:0] RLO   = RECIP[31:0];
    localparam int unsigned QW    = 65 - SH;
    localparam logic [AW:0] KC    = (AW + 1)'(DATA_WORDS);

    logic [XLEN-1:0]  x1_q, x2_q;
    logic [63:0]      p1_q;
    logic [QW-1:0]    q2_q;
    logic [AW:0]      r3_q;
    logic [AW-1:0]    r4_q;
    logic [64:0]      sum2;
    logic [QW+AW:0]   qk;
    logic [XLEN-1:0]  r3;

    assign sum2 = {1'b0, p1_q} + {1'b0, x1_q, 32'd0};
    assign qk   = (QW + AW + 1)'(q2_q) * (QW + AW + 1)'(KC);
    assign r3   = x2_q - qk[XLEN-1:0];

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        p1_q <= 64'(x_i) * 64'(RLO);
        x1_q <= x_i;
        q2_q <= sum2[64:SH];
        x2_q <= x1_q;
        r3_q <= r3[AW:0];
        r4_q <= (r3_q >= KC) ? AW'(r3_q - KC) : r3_q[AW-1:0];
      end
    end

    assign idx_o = r4_q;
  end

endmodule

`default_nettype wire

[rtl/srie_back.sv]
// back end: register file, execute, data store and write-back
`timescale 1ns / 1ps
`default_nettype none

module srie_back import srie_pkg::*; #(
  parameter int unsigned DATA_WORDS = DATA_WORDS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic fq_empty_i,
  input  wire dec_t fq_head_i,
  output logic      fq_pop_o,
  output logic      clr_busy_o,
  input  wire logic oq_full_i,
  output logic      oq_push_o,
  output res_t      oq_data_o
);

  localparam int unsigned AW  = $clog2(DATA_WORDS);
  localparam int unsigned NST = dmod_lat(DATA_WORDS) + 2;
  localparam int unsigned MST = NST - 2;
  localparam int unsigned WST = NST - 1;

  typedef struct packed {
    logic              wr;
    logic              is_ld;
    logic              is_st;
    logic [RIDX_W-1:0] rd;
    logic [XLEN-1:0]   val;
    logic [XLEN-1:0]   st_data;
    logic [XLEN-1:0]   addr;
    logic [XLEN-1:0]   next_pc;
    logic              br;
    logic              bad;
  } stg_t;

  // execute stage
  logic            ex_v_q;
  dec_t            ex_q;
  logic [XLEN-1:0] pc_q;

  // post-execute stages, index 0 is the youngest
  logic [NST-1:0]  pv_q;
  stg_t            pd_q [NST];
  stg_t            p_new;

  // register file
  logic [XLEN-1:0]   rf_mem [NREGS];
  logic [NREGS-1:0]  rf_vld_q;
  logic [XLEN-1:0]   rd1_q, rd2_q;
  logic              z1_q, z2_q;
  logic [RIDX_W-1:0] rf_a1, rf_a2;

  // data store
  logic [XLEN-1:0]    dm_mem [DATA_WORDS];
  logic [XLEN-1:0]    dm_rd_q;
  logic [AW-1:0]      dm_idx;
  logic [AW-1:0]      dm_waddr;
  logic [XLEN-1:0]    dm_wdata;
  logic               dm_we, dm_re;
  logic               clr_q;
  logic [AW-1:0]      clr_cnt_q;
  logic [XLEN-1:0]    idx_ext;
  logic [MADDR_W-1:0] wb_maddr_q;

  logic              adv, ex_adv, ex_load, issue, hazard;
  logic [XLEN-1:0]   fwd1, fwd2;
  logic              hz1, hz2;
  logic              wb_we;
  logic [XLEN-1:0]   wb_val;
  logic [RIDX_W-1:0] wb_rd;
  logic [XLEN-1:0]   res, pc_inc, pc_nx, addr;
  logic              br;

  assign adv     = !(pv_q[WST] && oq_full_i);
  assign ex_adv  = adv && ex_v_q && !hazard;
  assign ex_load = !ex_v_q || ex_adv;
  assign issue   = ex_load && !fq_empty_i && !clr_q;

  assign fq_pop_o   = issue;
  assign clr_busy_o = clr_q;

  assign rf_a1 = issue ? fq_head_i.ra : ex_q.ra;
  assign rf_a2 = issue ? fq_head_i.rb : ex_q.rb;

  assign wb_rd  = pd_q[WST].rd;
  assign wb_we  = pv_q[WST] && pd_q[WST].wr && adv;
  assign wb_val = pd_q[WST].is_ld ? dm_rd_q : pd_q[WST].val;

  // operand bypass from the younger stages wins
  always_comb begin
    fwd1 = z1_q ? '0 : rd1_q;
    fwd2 = z2_q ? '0 : rd2_q;
    hz1  = 1'b0;
    hz2  = 1'b0;
    for (int k = NST - 1; k >= 0; k--) begin
      if (pv_q[k] && pd_q[k].wr && (pd_q[k].rd == ex_q.ra)) begin
        if (pd_q[k].is_ld && (k != int'(WST))) begin
          hz1 = 1'b1;
        end else begin
          hz1  = 1'b0;
          fwd1 = pd_q[k].is_ld ? dm_rd_q : pd_q[k].val;
        end
      end
      if (pv_q[k] && pd_q[k].wr && (pd_q[k].rd == ex_q.rb)) begin
        if (pd_q[k].is_ld && (k != int'(WST))) begin
          hz2 = 1'b1;
        end else begin
          hz2  = 1'b0;
          fwd2 = pd_q[k].is_ld ? dm_rd_q : pd_q[k].val;
        end
      end
    end
  end

  assign hazard = ex_v_q && ((ex_q.use_ra && hz1) || (ex_q.use_rb && hz2));

  always_comb begin
    res    = '0;
    br     = 1'b0;
    pc_inc = pc_q + 32'd1;
    pc_nx  = pc_inc;
    addr   = fwd1 + ex_q.imm;
    case (ex_q.op)
      OP_ADD:  res = ex_q.bad ? '0 : fwd1 + fwd2;
      OP_SUB:  res = fwd1 - fwd2;
      OP_MULI: res = fwd1 * ex_q.imm;
      OP_ADDI: res = addr;
      OP_BNE: begin
        if (fwd2 != fwd1) begin
          pc_nx = pc_inc + ex_q.imm;
          br    = 1'b1;
        end
      end
      OP_ANDI: res = fwd1 & ex_q.imm;
      OP_ORI:  res = fwd1 | ex_q.imm;
      OP_J: begin
        pc_nx = {pc_q[XLEN-1:JADDR_W], ex_q.jaddr};
        br    = 1'b1;
      end
      OP_SLL:  res = (ex_q.shamt < SHAMT_W'(XLEN)) ? (fwd1 << ex_q.shamt[4:0]) : '0;
      OP_SRL:  res = (ex_q.shamt < SHAMT_W'(XLEN)) ? (fwd1 >> ex_q.shamt[4:0]) : '0;
      default: res = '0;
    endcase
  end

  always_comb begin
    p_new         = '0;
    p_new.wr      = ex_q.wr;
    p_new.is_ld   = ex_q.is_ld;
    p_new.is_st   = ex_q.is_st;
    p_new.rd      = ex_q.rd;
    p_new.val     = res;
    p_new.st_data = ex_q.is_st ? fwd2 : '0;
    p_new.addr    = addr;
    p_new.next_pc = pc_nx;
    p_new.br      = br;
    p_new.bad     = ex_q.bad;
  end

  srie_dmod #(.DATA_WORDS(DATA_WORDS)) u_dmod (
    .clk_i (clk_i),
    .adv_i (adv),
    .x_i   (pd_q[0].addr),
    .idx_o (dm_idx)
  );

  assign idx_ext  = XLEN'(dm_idx);
  assign dm_re    = adv && pv_q[MST] && pd_q[MST].is_ld;
  assign dm_we    = clr_q || (adv && pv_q[MST] && pd_q[MST].is_st);
  assign dm_waddr = clr_q ? clr_cnt_q : dm_idx;
  assign dm_wdata = clr_q ? '0 : pd_q[MST].st_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_v_q    <= 1'b0;
      pc_q      <= '0;
      pv_q      <= '0;
      rf_vld_q  <= '0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      if (ex_load) begin
        ex_v_q <= issue;
      end
      if (ex_adv) begin
        pc_q <= pc_nx;
      end
      if (adv) begin
        pv_q <= {pv_q[NST-2:0], ex_adv};
      end
      if (wb_we) begin
        rf_vld_q[wb_rd] <= 1'b1;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(DATA_WORDS - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_load) begin
      ex_q <= fq_head_i;
    end
    if (adv) begin
      pd_q[0]    <= p_new;
      wb_maddr_q <= idx_ext[MADDR_W-1:0];
      for (int k = 1; k < int'(NST); k++) begin
        pd_q[k] <= pd_q[k-1];
      end
    end
  end

  // register file, write-first on a same-cycle read
  always_ff @(posedge clk_i) begin
    if (wb_we) begin
      rf_mem[wb_rd] <= wb_val;
    end
    rd1_q <= (wb_we && (wb_rd == rf_a1)) ? wb_val : rf_mem[rf_a1];
    rd2_q <= (wb_we && (wb_rd == rf_a2)) ? wb_val : rf_mem[rf_a2];
    z1_q  <= !(wb_we && (wb_rd == rf_a1)) && !rf_vld_q[rf_a1];
    z2_q  <= !(wb_we && (wb_rd == rf_a2)) && !rf_vld_q[rf_a2];
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_mem[dm_waddr] <= dm_wdata;
    end
    if (dm_re) begin
      dm_rd_q <= dm_mem[dm_idx];
    end
  end

  assign oq_push_o = pv_q[WST] && adv;

  always_comb begin
    oq_data_o              = '0;
    oq_data_o.next_pc      = pd_q[WST].next_pc;
    oq_data_o.reg_write    = pd_q[WST].wr;
    oq_data_o.dest_reg     = pd_q[WST].wr ? wb_rd : '0;
    oq_data_o.write_value  = pd_q[WST].wr ? wb_val : '0;
    oq_data_o.mem_write    = pd_q[WST].is_st;
    oq_data_o.mem_address  = (pd_q[WST].is_ld || pd_q[WST].is_st) ? wb_maddr_q : '0;
    oq_data_o.mem_data     = pd_q[WST].st_data;
    oq_data_o.branch_taken = pd_q[WST].br;
    oq_data_o.bad_opcode   = pd_q[WST].bad;
  end

endmodule

`default_nettype wire

[rtl/simple_risc_instruction_executor.sv]
// top level of the instruction executor
// a transaction passes the decode queue, the execute register and the post-execute
// stages to the result side, and waits while the result queue is full; one transaction
// per cycle otherwise, but an instruction that reads the target of the load just ahead
// of it waits until that load reaches write-back, set by the data store read stage
// reset: the data store is cleared one word a cycle, full stays high until it is done
`timescale 1ns / 1ps
`default_nettype none

module simple_risc_instruction_executor import srie_pkg::*; #(
  parameter int unsigned DATA_WORDS = DATA_WORDS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [XLEN-1:0]      instruction_i,
  input  wire logic                 pop,
  output logic                      empty,
  output logic [XLEN-1:0]           next_pc_o,
  output logic                      reg_write_o,
  output logic [RIDX_W-1:0]         dest_reg_o,
  output logic signed [XLEN-1:0]    write_value_o,
  output logic                      mem_write_o,
  output logic [MADDR_W-1:0]        mem_address_o,
  output logic signed [XLEN-1:0]    mem_data_o,
  output logic                      branch_taken_o,
  output logic                      bad_opcode_o
);

  dec_t fq_head;
  logic fq_empty, fq_pop, clr_busy;
  logic oq_full, oq_push;
  res_t oq_data, oq_head;

  srie_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .instr_i (instruction_i),
    .hold_i  (clr_busy),
    .full_o  (full),
    .pop_i   (fq_pop),
    .head_o  (fq_head),
    .empty_o (fq_empty)
  );

  srie_back #(.DATA_WORDS(DATA_WORDS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fq_empty_i (fq_empty),
    .fq_head_i  (fq_head),
    .fq_pop_o   (fq_pop),
    .clr_busy_o (clr_busy),
    .oq_full_i  (oq_full),
    .oq_push_o  (oq_push),
    .oq_data_o  (oq_data)
  );

  srie_fifo #(.T(res_t)) u_oq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .data_i  (oq_data),
    .full_o  (oq_full),
    .pop_i   (pop),
    .data_o  (oq_head),
    .empty_o (empty)
  );

  assign next_pc_o      = oq_head.next_pc;
  assign reg_write_o    = oq_head.reg_write;
  assign dest_reg_o     = oq_head.dest_reg;
  assign write_value_o  = signed'(oq_head.write_value);
  assign mem_write_o    = oq_head.mem_write;
  assign mem_address_o  = oq_head.mem_address;
  assign mem_data_o     = signed'(oq_head.mem_data);
  assign branch_taken_o = oq_head.branch_taken;
  assign bad_opcode_o   = oq_head.bad_opcode;

endmodule

`default_nettype wire

[tb/tb.sv]
// self-checking testbench of the instruction executor with a built-in instruction-level predictor
`timescale 1ns / 1ps

module tb;
  import srie_pkg::*;

  localparam logic [3:0]  OP_RSVD    = 4'd12;
  localparam int unsigned DMEM_WORDS = DATA_WORDS_DEF;
  localparam int unsigned CYCLE_CAP  = 200000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      push = 1'b0;
  logic                      full;
  logic [XLEN-1:0]           instruction_i = '0;
  logic                      pop = 1'b0;
  logic                      empty;
  logic [XLEN-1:0]           next_pc_o;
  logic                      reg_write_o;
  logic [RIDX_W-1:0]         dest_reg_o;
  logic signed [XLEN-1:0]    write_value_o;
  logic                      mem_write_o;
  logic [MADDR_W-1:0]        mem_address_o;
  logic signed [XLEN-1:0]    mem_data_o;
  logic                      branch_taken_o;
  logic                      bad_opcode_o;

  logic [XLEN-1:0] arch_gpr [NREGS];
  logic [XLEN-1:0] arch_mem [DMEM_WORDS];
  logic [XLEN-1:0] arch_pc;
  res_t            expected_retire_q [$];
  res_t            retire_head;
  bit              steady = 1'b0;
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count = 0;

  simple_risc_instruction_executor uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .instruction_i  (instruction_i),
    .pop            (pop),
    .empty          (empty),
    .next_pc_o      (next_pc_o),
    .reg_write_o    (reg_write_o),
    .dest_reg_o     (dest_reg_o),
    .write_value_o  (write_value_o),
    .mem_write_o    (mem_write_o),
    .mem_address_o  (mem_address_o),
    .mem_data_o     (mem_data_o),
    .branch_taken_o (branch_taken_o),
    .bad_opcode_o   (bad_opcode_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic res_t retire_instruction(input logic [31:0] word);
    logic [3:0]  opc;
    logic [4:0]  ra_i;
    logic [4:0]  rb_i;
    logic [4:0]  rc_i;
    logic [12:0] sh;
    logic [31:0] imm;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] val;
    logic [31:0] pc_next;
    logic [31:0] ea;
    int unsigned slot;
    res_t        r;
    opc     = word[31:28];
    ra_i    = word[27:23];
    rb_i    = word[22:18];
    rc_i    = word[17:13];
    sh      = word[12:0];
    imm     = {{14{word[17]}}, word[17:0]};
    a       = arch_gpr[ra_i];
    b       = arch_gpr[rb_i];
    c       = arch_gpr[rc_i];
    r       = '0;
    val     = '0;
    pc_next = arch_pc + 32'd1;
    case (opc)
      OP_ADD:  begin val = b + c; r.reg_write = 1'b1; end
      OP_SUB:  begin val = b - c; r.reg_write = 1'b1; end
      OP_MULI: begin val = b * imm; r.reg_write = 1'b1; end
      OP_ADDI: begin val = b + imm; r.reg_write = 1'b1; end
      OP_ANDI: begin val = b & imm; r.reg_write = 1'b1; end
      OP_ORI:  begin val = b | imm; r.reg_write = 1'b1; end
      OP_BNE: begin
        if (a != b) begin
          pc_next        = arch_pc + 32'd1 + imm;
          r.branch_taken = 1'b1;
        end
      end
      OP_J: begin
        pc_next        = {arch_pc[31:28], word[27:0]};
        r.branch_taken = 1'b1;
      end
      OP_SLL: begin val = (sh < 13'd32) ? (b << sh[4:0]) : '0; r.reg_write = 1'b1; end
      OP_SRL: begin val = (sh < 13'd32) ? (b >> sh[4:0]) : '0; r.reg_write = 1'b1; end
      OP_LW: begin
        ea            = b + imm;
        slot          = ea % DMEM_WORDS;
        r.mem_address = slot[MADDR_W-1:0];
        val           = arch_mem[slot];
        r.reg_write   = 1'b1;
      end
      OP_SW: begin
        ea             = b + imm;
        slot           = ea % DMEM_WORDS;
        r.mem_address  = slot[MADDR_W-1:0];
        arch_mem[slot] = a;
        r.mem_data     = a;
        r.mem_write    = 1'b1;
      end
      default: r.bad_opcode = 1'b1;
    endcase
    if (ra_i == 5'd0) r.reg_write = 1'b0;
    if (r.reg_write) begin
      arch_gpr[ra_i] = val;
      r.dest_reg     = ra_i;
      r.write_value  = val;
    end
    arch_pc   = pc_next;
    r.next_pc = pc_next;
    return r;
  endfunction

  function automatic logic [31:0] enc_i(input logic [3:0] op, input logic [4:0] r1,
                                        input logic [4:0] r2, input logic [17:0] imm);
    return {op, r1, r2, imm};
  endfunction

  function automatic logic [31:0] enc_r(input logic [3:0] op, input logic [4:0] r1,
                                        input logic [4:0] r2, input logic [4:0] r3);
    return {op, r1, r2, r3, 13'($urandom)};
  endfunction

  function automatic logic [31:0] enc_sh(input logic [3:0] op, input logic [4:0] r1,
                                         input logic [4:0] r2, input logic [12:0] sh);
    return {op, r1, r2, 5'($urandom), sh};
  endfunction

  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 9) == 0) w[31:28] = OP_RSVD + 4'($urandom_range(0, 3));
    else w[31:28] = 4'($urandom_range(0, 11));
    if ($urandom_range(0, 1) == 1) begin
      w[27:23] = 5'($urandom_range(0, 3));
      w[22:18] = 5'($urandom_range(0, 3));
      w[17:13] = 5'($urandom_range(0, 3));
    end
    case ($urandom_range(0, 7))
      0: w[17:0] = 18'h1FFFF;
      1: w[17:0] = 18'h20000;
      2: w[17:0] = 18'h3FFFF;
      3: w[17:0] = 18'h00000;
      default: ;
    endcase
    if ((w[31:28] == OP_SLL || w[31:28] == OP_SRL) && $urandom_range(0, 2) != 0)
      w[12:0] = 13'($urandom_range(0, 31));
    return w;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
    end
  endfunction

  task automatic send_instruction(input logic [31:0] word);
    while (!steady && $urandom_range(0, 99) < 24) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    instruction_i <= word;
    do @(posedge clk_i); while (full);
    expected_retire_q.push_back(retire_instruction(word));
  endtask

  task automatic wait_retired();
    push <= 1'b0;
    while (expected_retire_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic test_each_opcode();
    send_instruction(enc_i(OP_ADDI, 5'd1, 5'd0, 18'h1FFFF));
    send_instruction(enc_i(OP_ADDI, 5'd2, 5'd0, 18'h20000));
    send_instruction(enc_i(OP_ADDI, 5'd31, 5'd0, 18'h3FFFF));
    send_instruction(enc_r(OP_ADD, 5'd3, 5'd1, 5'd2));
    send_instruction(enc_r(OP_SUB, 5'd4, 5'd2, 5'd1));
    send_instruction(enc_i(OP_MULI, 5'd5, 5'd1, 18'h1FFFF));
    send_instruction(enc_i(OP_MULI, 5'd30, 5'd31, 18'h3FFFF));
    send_instruction(enc_i(OP_ANDI, 5'd6, 5'd31, 18'h2AAAA));
    send_instruction(enc_i(OP_ORI, 5'd7, 5'd1, 18'h20000));
    // write to r0 is dropped
    send_instruction(enc_i(OP_ADDI, 5'd0, 5'd1, 18'h00005));
    send_instruction(enc_sh(OP_SLL, 5'd8, 5'd31, 13'd31));
    send_instruction(enc_sh(OP_SLL, 5'd9, 5'd1, 13'd32));
    send_instruction(enc_sh(OP_SRL, 5'd10, 5'd2, 13'd1));
    send_instruction(enc_sh(OP_SRL, 5'd11, 5'd31, 13'h1FFF));
    // data address wraps around the store
    send_instruction(enc_i(OP_SW, 5'd31, 5'd1, 18'h1FFFF));
    send_instruction(enc_i(OP_LW, 5'd12, 5'd1, 18'h1FFFF));
    send_instruction(enc_i(OP_LW, 5'd13, 5'd2, 18'h20000));
    send_instruction(enc_i(OP_SW, 5'd0, 5'd0, 18'h3FFFF));
    send_instruction(enc_i(OP_BNE, 5'd1, 5'd1, 18'h00010));
    // taken branch wraps the pc below zero
    send_instruction(enc_i(OP_BNE, 5'd1, 5'd2, 18'h20000));
    send_instruction({OP_J, 28'hFFFFFFF});
    send_instruction({OP_RSVD, 28'h0000000});
    send_instruction(32'hFFFFFFFF);
    send_instruction(enc_i(OP_BNE, 5'd0, 5'd31, 18'h1FFFF));
    send_instruction({OP_J, 28'h0000000});
  endtask

  task automatic test_store_load_sequences(input int unsigned bursts);
    logic [4:0]  base;
    logic [4:0]  dst;
    int unsigned n;
    int unsigned k;
    for (n = 0; n < bursts; n++) begin
      base = 5'($urandom_range(1, 31));
      send_instruction(enc_i(OP_ADDI, base, 5'd0, 18'($urandom_range(0, 1023))));
      for (k = 0; k < 8; k++) begin
        dst = 5'($urandom);
        case ($urandom_range(0, 4))
          0, 1: send_instruction(enc_i(OP_SW, dst, base, 18'($urandom_range(0, 7))));
          2: begin
            send_instruction(enc_i(OP_LW, dst, base, 18'($urandom_range(0, 7))));
            send_instruction(enc_r(OP_ADD, 5'($urandom), dst, 5'($urandom)));
          end
          3: send_instruction(enc_i(OP_LW, dst, base, 18'($urandom_range(0, 7))));
          default: send_instruction(random_instruction());
        endcase
      end
      if (n == bursts / 2) wait_retired();
    end
  endtask

  task automatic test_random_mix(input int unsigned count);
    repeat (count) send_instruction(random_instruction());
  endtask

  task automatic test_back_to_back(input int unsigned count);
    steady = 1'b1;
    repeat (count) send_instruction(random_instruction());
    steady = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_retire_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no transaction pending, next_pc actual %h",
                 $time, next_pc_o);
      end else begin
        retire_head = expected_retire_q.pop_front();
        check_field("next_pc", retire_head.next_pc, next_pc_o);
        check_field("reg_write", 32'(retire_head.reg_write), 32'(reg_write_o));
        check_field("dest_reg", 32'(retire_head.dest_reg), 32'(dest_reg_o));
        check_field("write_value", retire_head.write_value, write_value_o);
        check_field("mem_write", 32'(retire_head.mem_write), 32'(mem_write_o));
        check_field("mem_address", 32'(retire_head.mem_address), 32'(mem_address_o));
        check_field("mem_data", retire_head.mem_data, mem_data_o);
        check_field("branch_taken", 32'(retire_head.branch_taken), 32'(branch_taken_o));
        check_field("bad_opcode", 32'(retire_head.bad_opcode), 32'(bad_opcode_o));
      end
    end
    pop <= steady || ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    foreach (arch_gpr[i]) arch_gpr[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;
    arch_pc = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_each_opcode();
    test_store_load_sequences(30);
    test_random_mix(880);
    test_back_to_back(250);
    wait_retired();
    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
